/* rtl/sbp_pkg.sv */
package sbp_pkg;

  localparam int MaxBands = 32;
  localparam int CmdDepth = 2;
  localparam int OutDepth = 4;

  localparam logic [31:0] BinWidthRst = 32'h0001_0000;
  localparam logic [5:0]  BandCapRst  = 6'd32;
  localparam logic [63:0] AccFloor    = 64'd2;

  // log2(10)/10 in Q.24 and 10*log10(2) in Q.16
  localparam logic signed [39:0] Log2TenDiv10 = 40'sd5573271;
  localparam logic signed [55:0] DbPerLog2    = 56'sd197283;
  localparam logic signed [55:0] DbRound      = 56'sd8388608;

  localparam int ExpSteps  = 20;
  localparam int NormSteps = 6;
  localparam int LogSteps  = 16;

  localparam logic [6:0] AccFracBits  = 7'd34;
  localparam logic [6:0] FreqFracBits = 7'd16;
  localparam logic signed [7:0] TermShift = 8'sd12;

  localparam logic signed [15:0] DbMin = 16'sh8000;
  localparam logic signed [15:0] DbMax = 16'sh7FFF;

  // configuration register indexes
  localparam logic [1:0] CfgBinWidth = 2'd0;
  localparam logic [1:0] CfgBandCap  = 2'd1;
  localparam logic [1:0] CfgDensity  = 2'd2;

  // input mode codes
  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeBin   = 2'd1;
  localparam logic [1:0] ModeStart = 2'd2;

  typedef enum logic [1:0] {
    OpLoad,
    OpBin,
    OpStart
  } sbp_op_e;

  typedef enum logic [1:0] {
    LgIdle,
    LgNorm,
    LgSquare
  } sbp_log_st_e;

  typedef enum logic [4:0] {
    BIdle,
    BLoad,
    BStart,
    BBin,
    BChk,
    BRdLo,
    BRdHi,
    BEval,
    BExp,
    BMulW,
    BShift,
    BAcc,
    BCov,
    BCls,
    BLgAcc,
    BLgCov,
    BLgBw,
    BDb,
    BRnd,
    BEmit,
    BEnd
  } sbp_back_st_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         edge_index;
    logic [31:0]        edge_freq;
    logic signed [15:0] level_db;
  } sbp_in_t;

  typedef struct packed {
    logic [4:0]         band_index;
    logic signed [15:0] band_level_db;
    logic               status;
    logic               last;
  } sbp_out_t;

  typedef struct packed {
    sbp_op_e            op;
    logic [5:0]         edge_index;
    logic [31:0]        edge_freq;
    logic signed [15:0] level_db;
  } sbp_cmd_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [6:0]  fb;
  } sbp_log_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] l;
  } sbp_log_rsp_t;

  typedef logic [30:0] sbp_root_tab_t [ExpSteps];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = v;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != '0) begin
        if (x >= res + b) begin
          x   = x - res - b;
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // factors 2^(2^-j), j = 1..ExpSteps, Q1.30, each the root of the one before
  function automatic sbp_root_tab_t root_table();
    sbp_root_tab_t t;
    logic [63:0]   r;
    r = 64'd2 << 30;
    for (int j = 0; j < ExpSteps; j++) begin
      r    = isqrt64(r << 30);
      t[j] = 31'(r);
    end
    return t;
  endfunction

endpackage

/* rtl/sbp_fifo.sv */
module sbp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

/* rtl/sbp_front.sv */
module sbp_front #(
  parameter int MaxBands = sbp_pkg::MaxBands
) (
  input  logic              push_i,
  input  sbp_pkg::sbp_in_t  item_i,
  output logic              full_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output sbp_pkg::sbp_cmd_t q_cmd_o
);

  logic            keep;
  sbp_pkg::sbp_op_e op;

  // classify the item; drop unknown modes and loads beyond the edge table
  always_comb begin
    keep = 1'b0;
    op   = sbp_pkg::OpBin;
    unique case (item_i.mode)
      sbp_pkg::ModeLoad: begin
        op   = sbp_pkg::OpLoad;
        keep = (32'(item_i.edge_index) <= 32'(MaxBands));
      end
      sbp_pkg::ModeBin: begin
        op   = sbp_pkg::OpBin;
        keep = 1'b1;
      end
      sbp_pkg::ModeStart: begin
        op   = sbp_pkg::OpStart;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full_o              = q_full_i;
  assign q_push_o            = push_i && !q_full_i && keep;
  assign q_cmd_o.op          = op;
  assign q_cmd_o.edge_index  = item_i.edge_index;
  assign q_cmd_o.edge_freq   = item_i.edge_freq;
  assign q_cmd_o.level_db    = item_i.level_db;

endmodule

/* rtl/sbp_log2.sv */
module sbp_log2 (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sbp_pkg::sbp_log_req_t req_i,
  output sbp_pkg::sbp_log_rsp_t rsp_o
);

  sbp_pkg::sbp_log_st_e state_q, state_d;
  logic [63:0]        x_q, x_d;
  logic [5:0]         pos_q, pos_d;
  logic [6:0]         fb_q, fb_d;
  logic [3:0]         step_q, step_d;
  logic [15:0]        fr_q, fr_d;
  logic               done_q, done_d;
  logic [5:0]         amt;
  logic [63:0]        hi_mask;
  logic [61:0]        sq;
  logic [31:0]        sq_top;
  logic signed [7:0]  expo;

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    pos_d   = pos_q;
    fb_d    = fb_q;
    step_d  = step_q;
    fr_d    = fr_q;
    done_d  = 1'b0;
    amt     = 6'(7'd32 >> step_q[2:0]);
    hi_mask = ~({64{1'b1}} >> amt);
    sq      = 62'(x_q[30:0]) * 62'(x_q[30:0]);
    sq_top  = sq[61:30];
    unique case (state_q)
      sbp_pkg::LgIdle: begin
        if (req_i.start) begin
          x_d     = req_i.x;
          fb_d    = req_i.fb;
          pos_d   = 6'd63;
          step_d  = '0;
          fr_d    = '0;
          state_d = sbp_pkg::LgNorm;
        end
      end
      sbp_pkg::LgNorm: begin
        // binary search for the leading one, then take the mantissa in Q1.30
        if (step_q == 4'(sbp_pkg::NormSteps)) begin
          x_d     = 64'(x_q[63:33]);
          step_d  = '0;
          state_d = sbp_pkg::LgSquare;
        end else begin
          if ((x_q & hi_mask) == '0) begin
            x_d   = x_q << amt;
            pos_d = pos_q - amt;
          end
          step_d = step_q + 1'b1;
        end
      end
      sbp_pkg::LgSquare: begin
        fr_d   = {fr_q[14:0], sq_top[31]};
        x_d    = 64'(sq_top[31] ? sq_top[31:1] : sq_top[30:0]);
        step_d = step_q + 1'b1;
        if (step_q == 4'(sbp_pkg::LogSteps - 1)) begin
          done_d  = 1'b1;
          state_d = sbp_pkg::LgIdle;
        end
      end
      default: state_d = sbp_pkg::LgIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbp_pkg::LgIdle;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    pos_q <= pos_d;
    fb_q  <= fb_d;
    fr_q  <= fr_d;
  end

  assign expo       = $signed({2'b00, pos_q}) - $signed({1'b0, fb_q});
  assign rsp_o.done = done_q;
  assign rsp_o.l    = $signed({{8{expo[7]}}, expo, fr_q});

endmodule

/* rtl/sbp_back.sv */
module sbp_back #(
  parameter int MaxBands = sbp_pkg::MaxBands
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  input  sbp_pkg::sbp_cmd_t     cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output sbp_pkg::sbp_out_t     out_o,
  input  logic [31:0]           bin_width_i,
  input  logic [5:0]            band_cap_i,
  input  logic                  density_i,
  output sbp_pkg::sbp_log_req_t log_req_o,
  input  sbp_pkg::sbp_log_rsp_t log_rsp_i
);

  localparam int AW = $clog2(MaxBands + 1);
  localparam sbp_pkg::sbp_root_tab_t RootTab = sbp_pkg::root_table();

  sbp_pkg::sbp_back_st_e state_q, state_d;
  sbp_pkg::sbp_cmd_t     cmd_q, cmd_d;
  sbp_pkg::sbp_out_t     pend_q, pend_d;
  logic                  pend_v_q, pend_v_d;
  logic [AW-1:0]         cb_q, cb_d, cb_next, rd_addr;
  logic [63:0]           acc_q, acc_d;
  logic [31:0]           freq_q, freq_d;
  logic [15:0]           pts_q, pts_d;
  logic                  halt_q, halt_d;
  logic                  lg_wait_q, lg_wait_d;
  logic [31:0]           lo_q, lo_d, hi_q, hi_d, rd_q;
  logic signed [39:0]    y_q, y_d;
  logic [31:0]           nf_q, nf_d;
  logic [30:0]           m_q, m_d;
  logic [4:0]            j_q, j_d;
  logic [62:0]           p_q, p_d;
  logic [63:0]           term_q, term_d;
  logic [47:0]           cov_q, cov_d;
  logic signed [31:0]    l_q, l_d;
  logic signed [55:0]    t_q, t_d;
  logic signed [15:0]    lvl_q, lvl_d;

  logic [31:0]           edge_mem [MaxBands + 1];

  logic [31:0]           cap;
  logic                  halt_new;
  logic [19:0]           yf;
  logic [61:0]           prod;
  logic signed [7:0]     sh;
  logic [7:0]            sh_neg;
  logic [127:0]          wide;
  logic [64:0]           sum;
  logic [32:0]           nf_sum;
  logic signed [55:0]    rnd;

  assign cap      = (32'(band_cap_i) > 32'(MaxBands)) ? 32'(MaxBands) : 32'(band_cap_i);
  assign cb_next  = cb_q + 1'b1;
  assign halt_new = (32'(cb_next) >= cap);
  assign rd_addr  = (state_q == sbp_pkg::BChk) ? cb_q : cb_next;
  assign yf       = y_q[31:12];

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    cb_d      = cb_q;
    acc_d     = acc_q;
    freq_d    = freq_q;
    pts_d     = pts_q;
    halt_d    = halt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    y_d       = y_q;
    nf_d      = nf_q;
    m_d       = m_q;
    j_d       = j_q;
    p_d       = p_q;
    term_d    = term_q;
    cov_d     = cov_q;
    l_d       = l_q;
    t_d       = t_q;
    lvl_d     = lvl_q;
    cmd_pop_o = 1'b0;
    out_push_o = 1'b0;
    out_o     = pend_q;
    log_req_o.start = 1'b0;
    log_req_o.x     = acc_q;
    log_req_o.fb    = sbp_pkg::AccFracBits;
    prod   = 62'(m_q) * 62'(RootTab[j_q]);
    sh     = $signed(y_q[39:32]) - sbp_pkg::TermShift;
    sh_neg = 8'(-sh);
    wide   = 128'(p_q) << 7'(sh);
    sum    = 65'(acc_q) + 65'(term_q);
    nf_sum = 33'(freq_q) + 33'(bin_width_i);
    rnd    = (t_q + sbp_pkg::DbRound) >>> 24;

    unique case (state_q)
      sbp_pkg::BIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          unique case (cmd_i.op)
            sbp_pkg::OpLoad:  state_d = sbp_pkg::BLoad;
            sbp_pkg::OpStart: state_d = sbp_pkg::BStart;
            default:          state_d = sbp_pkg::BBin;
          endcase
        end
      end
      sbp_pkg::BLoad: state_d = sbp_pkg::BIdle;
      sbp_pkg::BStart: begin
        cb_d    = '0;
        acc_d   = sbp_pkg::AccFloor;
        freq_d  = '0;
        pts_d   = '0;
        halt_d  = 1'b0;
        state_d = sbp_pkg::BIdle;
      end
      sbp_pkg::BBin: begin
        if (halt_q) begin
          state_d = sbp_pkg::BIdle;
        end else begin
          y_d     = 40'(cmd_q.level_db) * sbp_pkg::Log2TenDiv10;
          nf_d    = nf_sum[32] ? '1 : nf_sum[31:0];
          state_d = sbp_pkg::BChk;
        end
      end
      sbp_pkg::BChk: begin
        if (32'(cb_q) >= 32'(MaxBands)) begin
          halt_d  = 1'b1;
          state_d = sbp_pkg::BEnd;
        end else begin
          state_d = sbp_pkg::BRdLo;
        end
      end
      sbp_pkg::BRdLo: begin
        lo_d    = rd_q;
        state_d = sbp_pkg::BRdHi;
      end
      sbp_pkg::BRdHi: begin
        hi_d    = rd_q;
        state_d = sbp_pkg::BEval;
      end
      sbp_pkg::BEval: begin
        if (freq_q >= lo_q && freq_q < hi_q) begin
          m_d     = 31'(64'd1 << 30);
          j_d     = '0;
          state_d = sbp_pkg::BExp;
        end else if (freq_q >= hi_q) begin
          state_d = sbp_pkg::BCov;
        end else begin
          state_d = sbp_pkg::BEnd;
        end
      end
      sbp_pkg::BExp: begin
        // one root factor per cycle for each set fraction bit
        if (yf[5'(sbp_pkg::ExpSteps - 1) - j_q]) m_d = prod[60:30];
        j_d = j_q + 1'b1;
        if (j_q == 5'(sbp_pkg::ExpSteps - 1)) state_d = sbp_pkg::BMulW;
      end
      sbp_pkg::BMulW: begin
        p_d     = 63'(m_q) * 63'(bin_width_i);
        state_d = sbp_pkg::BShift;
      end
      sbp_pkg::BShift: begin
        if (sh < 0) begin
          term_d = (sh_neg >= 8'd64) ? '0 : (64'(p_q) >> sh_neg);
        end else begin
          term_d = (wide[127:64] != '0) ? '1 : wide[63:0];
        end
        state_d = sbp_pkg::BAcc;
      end
      sbp_pkg::BAcc: begin
        acc_d   = sum[64] ? '1 : sum[63:0];
        pts_d   = (pts_q == '1) ? pts_q : pts_q + 1'b1;
        state_d = sbp_pkg::BEnd;
      end
      sbp_pkg::BCov: begin
        cov_d   = 48'(pts_q) * 48'(bin_width_i);
        state_d = sbp_pkg::BCls;
      end
      sbp_pkg::BCls: begin
        if (cov_q == '0 || acc_q == '0) begin
          lvl_d   = sbp_pkg::DbMin;
          state_d = sbp_pkg::BEmit;
        end else if (!density_i && hi_q <= lo_q) begin
          lvl_d   = sbp_pkg::DbMin;
          state_d = sbp_pkg::BEmit;
        end else begin
          state_d = sbp_pkg::BLgAcc;
        end
      end
      sbp_pkg::BLgAcc: begin
        log_req_o.start = !lg_wait_q;
        if (log_rsp_i.done) begin
          l_d     = log_rsp_i.l;
          state_d = sbp_pkg::BLgCov;
        end
      end
      sbp_pkg::BLgCov: begin
        log_req_o.start = !lg_wait_q;
        log_req_o.x     = 64'(cov_q);
        log_req_o.fb    = sbp_pkg::FreqFracBits;
        if (log_rsp_i.done) begin
          if (density_i) begin
            l_d     = l_q - log_rsp_i.l;
            state_d = sbp_pkg::BDb;
          end else begin
            l_d     = l_q + log_rsp_i.l;
            state_d = sbp_pkg::BLgBw;
          end
        end
      end
      sbp_pkg::BLgBw: begin
        log_req_o.start = !lg_wait_q;
        log_req_o.x     = 64'(hi_q - lo_q);
        log_req_o.fb    = sbp_pkg::FreqFracBits;
        if (log_rsp_i.done) begin
          l_d     = l_q - log_rsp_i.l;
          state_d = sbp_pkg::BDb;
        end
      end
      sbp_pkg::BDb: begin
        t_d     = 56'(l_q) * sbp_pkg::DbPerLog2;
        state_d = sbp_pkg::BRnd;
      end
      sbp_pkg::BRnd: begin
        if (rnd < 56'(sbp_pkg::DbMin)) lvl_d = sbp_pkg::DbMin;
        else if (rnd > 56'(sbp_pkg::DbMax)) lvl_d = sbp_pkg::DbMax;
        else lvl_d = 16'(rnd);
        state_d = sbp_pkg::BEmit;
      end
      sbp_pkg::BEmit: begin
        // hold the new result back until we know whether another band closes
        if (!pend_v_q || !out_full_i) begin
          if (pend_v_q) begin
            out_push_o = 1'b1;
            out_o.last = 1'b0;
          end
          pend_d.band_index    = 5'(cb_q);
          pend_d.band_level_db = lvl_q;
          pend_d.status        = halt_new;
          pend_d.last          = 1'b0;
          pend_v_d = 1'b1;
          cb_d     = cb_next;
          pts_d    = '0;
          acc_d    = sbp_pkg::AccFloor;
          halt_d   = halt_new;
          state_d  = halt_new ? sbp_pkg::BEnd : sbp_pkg::BChk;
        end
      end
      sbp_pkg::BEnd: begin
        if (!pend_v_q || !out_full_i) begin
          if (pend_v_q) begin
            out_push_o = 1'b1;
            out_o.last = 1'b1;
          end
          pend_v_d = 1'b0;
          freq_d   = nf_q;
          state_d  = sbp_pkg::BIdle;
        end
      end
      default: state_d = sbp_pkg::BIdle;
    endcase
  end

  assign lg_wait_d = log_req_o.start ? 1'b1 : (log_rsp_i.done ? 1'b0 : lg_wait_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sbp_pkg::BIdle;
      pend_v_q  <= 1'b0;
      cb_q      <= '0;
      acc_q     <= sbp_pkg::AccFloor;
      freq_q    <= '0;
      pts_q     <= '0;
      halt_q    <= 1'b0;
      lg_wait_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_v_q  <= pend_v_d;
      cb_q      <= cb_d;
      acc_q     <= acc_d;
      freq_q    <= freq_d;
      pts_q     <= pts_d;
      halt_q    <= halt_d;
      lg_wait_q <= lg_wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pend_q <= pend_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    y_q    <= y_d;
    nf_q   <= nf_d;
    m_q    <= m_d;
    j_q    <= j_d;
    p_q    <= p_d;
    term_q <= term_d;
    cov_q  <= cov_d;
    l_q    <= l_d;
    t_q    <= t_d;
    lvl_q  <= lvl_d;
  end

  // band edge table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == sbp_pkg::BLoad) edge_mem[AW'(cmd_q.edge_index)] <= cmd_q.edge_freq;
    rd_q <= edge_mem[rd_addr];
  end

endmodule

/* rtl/spectrum_band_power_integrator_core.sv */
// Band power integrator: items come in through a queue-style port (mode 0 loads a band
// edge, mode 1 delivers one dB spectrum bin, mode 2 starts a run) and band results leave
// through a second queue-style port, one per closed band, the last one of an item flagged.
// A bin inside the current band runs the 20-step 2^x sequence on the 31x31 multiplier.
// Each band that a bin closes takes two logs in density mode and three in ratio mode on
// the iterative log2 unit (6 normalize steps and 16 squaring steps per log); an empty
// band, or in ratio mode an inverted one, closes at the minimum level without a log. A
// two-entry command queue lets loads and bins enter while a band is closed, and
// a four-entry result queue holds results while the consumer stalls. The band edge table is
// not cleared at reset: every edge a run uses must be loaded first.
module spectrum_band_power_integrator_core #(
  parameter int MaxBands = sbp_pkg::MaxBands
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sbp_pkg::sbp_in_t  in_i,
  output logic              empty,
  input  logic              pop,
  output sbp_pkg::sbp_out_t out_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);

  logic [31:0]           bin_width_q;
  logic [5:0]            band_cap_q;
  logic                  density_q;

  logic                  q_push, q_full, q_empty, q_pop;
  sbp_pkg::sbp_cmd_t     q_cmd_in, q_cmd_out;
  logic                  o_push, o_full;
  sbp_pkg::sbp_out_t     o_data;
  sbp_pkg::sbp_log_req_t log_req;
  sbp_pkg::sbp_log_rsp_t log_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= sbp_pkg::BinWidthRst;
      band_cap_q  <= sbp_pkg::BandCapRst;
      density_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbp_pkg::CfgBinWidth: bin_width_q <= cfg_data_i;
        sbp_pkg::CfgBandCap:  band_cap_q  <= cfg_data_i[5:0];
        sbp_pkg::CfgDensity:  density_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sbp_front #(
    .MaxBands(MaxBands)
  ) u_front (
    .push_i   (push),
    .item_i   (in_i),
    .full_o   (full),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd_in)
  );

  sbp_fifo #(
    .Width($bits(sbp_pkg::sbp_cmd_t)),
    .Depth(sbp_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_cmd_out),
    .empty_o (q_empty)
  );

  sbp_back #(
    .MaxBands(MaxBands)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .out_full_i  (o_full),
    .out_push_o  (o_push),
    .out_o       (o_data),
    .bin_width_i (bin_width_q),
    .band_cap_i  (band_cap_q),
    .density_i   (density_q),
    .log_req_o   (log_req),
    .log_rsp_i   (log_rsp)
  );

  sbp_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (log_req),
    .rsp_o  (log_rsp)
  );

  sbp_fifo #(
    .Width($bits(sbp_pkg::sbp_out_t)),
    .Depth(sbp_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .data_i  (o_data),
    .full_o  (o_full),
    .pop_i   (pop),
    .data_o  (out_o),
    .empty_o (empty)
  );

endmodule
